// ===== sv/u16_table_linear_interpolator_assert.svh =====
// Assertion macros for the u16 table linear interpolator.
// Used by the checker; no other dependencies.
`ifndef U16_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH
`define U16_TABLE_LINEAR_INTERPOLATOR_ASSERT_SVH

// Check that post holds in the same cycle as pre
`define UTI_ASSERT_SAME(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |-> (post)) \
      else $error("assertion failed");

// Check that post holds in the cycle after pre
`define UTI_ASSERT_NEXT(label, clk, rst, pre, post) \
   label: assert property (@(posedge clk) disable iff (rst) (pre) |=> (post)) \
      else $error("assertion failed");

`endif

// ===== sv/uti_pkg.sv =====
// Package for the u16 table linear interpolator: types, constants, helpers.
// No dependencies.
package uti_pkg;

   localparam int UTI_TABLE_DEPTH = 64;
   localparam logic [30:0] UTI_ONE_BITS = 31'h3F800000;
   localparam logic [7:0] UTI_FRAC_WIDE = 8'd47;

   typedef enum logic [1:0] {
      MODE_LOWER  = 2'd0,
      MODE_UPPER  = 2'd1,
      MODE_INTERP = 2'd2
   } mode_type;

   typedef struct packed {
      logic     valid;
      logic     flag;
      mode_type mode;
   } ctl_type;

   // Position of the highest set bit (zero for a zero word)
   function automatic logic [5:0] top_bit(input logic [63:0] x);
      logic [5:0] n;
      n = 6'd0;
      for (int b = 0; b < 64; b++) begin
         if (x[b]) n = 6'(b);
      end
      return n;
   endfunction

endpackage

// ===== sv/u16_table_linear_interpolator.sv =====
// Top level of the u16 table linear interpolator: handshake, table, FMA pipe.
// Depends on uti_pkg, uti_mem and uti_fma.
//
// The block takes one transfer per cycle, write or interpolate, while no
// result is stalled, and offers one result per interpolate transfer. The
// table memory is read at the accept edge for cells i and i+1 from
// two copies; the product, the aligned add, the leading-bit search and the
// rounding each take one pipeline stage, and the last stage is the output
// register. A stalled result halts the whole pipeline, so req_tready follows
// (no result waiting) or (rsp_tready), and is low during reset. Write
// transfers yield no result.
module u16_table_linear_interpolator
   import uti_pkg::*;
#(
   parameter int TABLE_DEPTH = UTI_TABLE_DEPTH
) (
   input  logic        clock,
   input  logic        reset,
   input  logic        req_tvalid,
   output logic        req_tready,
   // cell_index[5:0], cell_value[21:6], frac_bits[52:22], zero fill
   input  logic [55:0] req_tdata,
   // func
   input  logic        req_tuser,
   output logic        rsp_tvalid,
   input  logic        rsp_tready,
   // result_bits[30:0], zero fill
   output logic [31:0] rsp_tdata,
   // out_of_range
   output logic        rsp_tuser
);

   localparam int AW = (TABLE_DEPTH > 1) ? $clog2(TABLE_DEPTH) : 1;
   localparam logic [AW-1:0] LAST = AW'(TABLE_DEPTH - 1);

   logic          adv, accept;
   logic [5:0]    idx;
   logic [15:0]   val;
   logic [30:0]   tb;
   logic          in_range, is_last;
   logic [AW-1:0] a0, a1;
   ctl_type       s0_ctl_ff, s0_ctl_in;
   logic [30:0]   s0_tb_ff;
   logic [15:0]   v0, v1;
   logic [30:0]   res_bits;

   assign adv = !rsp_tvalid || rsp_tready;
   assign req_tready = adv && !reset;
   assign accept = req_tvalid && req_tready;
   assign idx = req_tdata[5:0];
   assign val = req_tdata[21:6];
   assign tb = req_tdata[52:22];

   // Clamp the index and pick the interpolation mode
   always_comb begin
      in_range = (int'(idx) < TABLE_DEPTH);
      a0 = in_range ? AW'(idx) : LAST;
      is_last = (a0 == LAST);
      a1 = is_last ? a0 : AW'(a0 + 1'b1);
      s0_ctl_in.valid = accept && req_tuser;
      s0_ctl_in.flag = (tb != 31'd0) && is_last;
      if (tb == 31'd0 || is_last) begin
         s0_ctl_in.mode = MODE_LOWER;
      end else if (tb >= UTI_ONE_BITS) begin
         s0_ctl_in.mode = MODE_UPPER;
      end else begin
         s0_ctl_in.mode = MODE_INTERP;
      end
   end

   uti_mem #(
      .DEPTH (TABLE_DEPTH),
      .AW    (AW)
   ) u_mem (
      .clock    (clock),
      .wr_en    (accept && !req_tuser && in_range),
      .wr_addr  (a0),
      .wr_data  (val),
      .rd_en    (adv),
      .rd_addr0 (a0),
      .rd_addr1 (a1),
      .rd_data0 (v0),
      .rd_data1 (v1)
   );

   // Hold the read-stage control alongside the memory data
   always_ff @(posedge clock) begin
      if (reset) begin
         s0_ctl_ff.valid <= 1'b0;
      end else if (adv) begin
         s0_ctl_ff <= s0_ctl_in;
      end
   end

   always_ff @(posedge clock) begin
      if (adv) begin
         s0_tb_ff <= tb;
      end
   end

   uti_fma u_fma (
      .clock     (clock),
      .reset     (reset),
      .adv       (adv),
      .ctl       (s0_ctl_ff),
      .v0        (v0),
      .v1        (v1),
      .tb        (s0_tb_ff),
      .res_valid (rsp_tvalid),
      .res_bits  (res_bits),
      .res_flag  (rsp_tuser)
   );

   assign rsp_tdata = {1'b0, res_bits};

endmodule

// ===== sv/uti_mem.sv =====
// Cell table: two copies of a synchronous memory, read at i and i+1.
// Depends on nothing but its parameters.
module uti_mem #(
   parameter int DEPTH = 64,
   parameter int AW    = $clog2(DEPTH)
) (
   input  logic          clock,
   input  logic          wr_en,
   input  logic [AW-1:0] wr_addr,
   input  logic [15:0]   wr_data,
   input  logic          rd_en,
   input  logic [AW-1:0] rd_addr0,
   input  logic [AW-1:0] rd_addr1,
   output logic [15:0]   rd_data0,
   output logic [15:0]   rd_data1
);

   logic [15:0] bank0_mem [DEPTH];
   logic [15:0] bank1_mem [DEPTH];

   // Write both copies
   always_ff @(posedge clock) begin
      if (wr_en) begin
         bank0_mem[wr_addr] <= wr_data;
         bank1_mem[wr_addr] <= wr_data;
      end
   end

   // Registered reads, held while the pipeline stalls
   always_ff @(posedge clock) begin
      if (rd_en) begin
         rd_data0 <= bank0_mem[rd_addr0];
         rd_data1 <= bank1_mem[rd_addr1];
      end
   end

endmodule

// ===== sv/uti_fma.sv =====
// Fused multiply-add pipeline: multiply, align and add, count, round.
// Depends on uti_pkg.
module uti_fma
   import uti_pkg::*;
(
   input  logic        clock,
   input  logic        reset,
   input  logic        adv,
   input  ctl_type     ctl,
   input  logic [15:0] v0,
   input  logic [15:0] v1,
   input  logic [30:0] tb,
   output logic        res_valid,
   output logic [30:0] res_bits,
   output logic        res_flag
);

   // Stage 1: product
   ctl_type     s1_ctl_ff, s1_ctl_in;
   logic [39:0] s1_mag_ff, s1_mag_in;
   logic [15:0] s1_v0_ff, s1_v1_ff;
   logic        s1_up_ff, s1_up_in;
   logic [7:0]  s1_k_ff, s1_k_in;
   // Stage 2: aligned sum
   logic        s2_valid_ff;
   logic        s2_flag_ff;
   logic [63:0] s2_x_ff, s2_x_in;
   logic [7:0]  s2_kk_ff, s2_kk_in;
   // Stage 3: leading bit
   logic        s3_valid_ff;
   logic        s3_flag_ff;
   logic [63:0] s3_x_ff;
   logic [7:0]  s3_kk_ff;
   logic [5:0]  s3_lead_ff, s3_lead_in;
   // Stage 4: result
   logic        s4_valid_ff;
   logic        s4_flag_ff;
   logic [30:0] s4_res_ff, s4_res_in;

   logic [7:0]  bexp;
   logic [23:0] mant;
   logic [15:0] diff;

   // Decode t and form the product with the cell difference
   always_comb begin
      bexp = tb[30:23];
      mant = (bexp == 8'd0) ? {1'b0, tb[22:0]} : {1'b1, tb[22:0]};
      s1_k_in = (bexp == 8'd0) ? 8'd149 : 8'(8'd150 - bexp);
      s1_up_in = (v1 >= v0);
      diff = s1_up_in ? 16'(v1 - v0) : 16'(v0 - v1);
      s1_mag_in = 40'(mant * diff);
      s1_ctl_in = ctl;
   end

   logic [7:0]  sh;
   logic [63:0] mask, mq, xa;
   logic        stk;

   // Align the product to the lower cell and add or subtract it, or pass one cell through
   always_comb begin
      sh = 8'(s1_k_ff - UTI_FRAC_WIDE);
      mask = (64'd1 << sh) - 64'd1;
      mq = 64'(s1_mag_ff) >> sh;
      stk = |(64'(s1_mag_ff) & mask);
      if (sh >= 8'd41) begin
         mq = 64'd0;
         stk = (s1_mag_ff != 40'd0);
      end
      xa = 64'(s1_v0_ff) << s1_k_ff;
      s2_x_in = 64'(s1_v0_ff);
      s2_kk_in = 8'd0;
      case (s1_ctl_ff.mode)
         MODE_LOWER: begin
            s2_x_in = 64'(s1_v0_ff);
         end
         MODE_UPPER: begin
            s2_x_in = 64'(s1_v1_ff);
         end
         MODE_INTERP: begin
            if (s1_k_ff <= UTI_FRAC_WIDE) begin
               s2_x_in = s1_up_ff ? xa + 64'(s1_mag_ff) : xa - 64'(s1_mag_ff);
               s2_kk_in = s1_k_ff;
            end else if (s1_v0_ff == 16'd0) begin
               s2_x_in = 64'(s1_mag_ff);
               s2_kk_in = s1_k_ff;
            end else begin
               xa = 64'(s1_v0_ff) << UTI_FRAC_WIDE;
               s2_x_in = s1_up_ff ? ((xa + mq) | 64'(stk))
                                  : ((xa - mq - 64'(stk)) | 64'(stk));
               s2_kk_in = UTI_FRAC_WIDE;
            end
         end
         default: begin
            s2_x_in = 64'(s1_v0_ff);
         end
      endcase
   end

   // Find the leading bit
   assign s3_lead_in = top_bit(s2_x_ff);

   logic signed [9:0] ex;
   logic [63:0] xn, xs;
   logic [24:0] rsum;
   logic        rnd;

   // Normalise and round to nearest-even
   always_comb begin
      ex = $signed({4'd0, s3_lead_ff}) + 10'sd127 - $signed({2'd0, s3_kk_ff});
      xs = s3_x_ff << (8'd149 - s3_kk_ff);
      xn = s3_x_ff << (6'd63 - s3_lead_ff);
      rnd = xn[39] & ((|xn[38:0]) | xn[40]);
      rsum = {1'b0, xn[63:40]} + 25'(rnd);
      if (rsum[24]) ex = ex + 10'sd1;
      if (s3_x_ff == 64'd0) begin
         s4_res_in = 31'd0;
      end else if (ex[9] || ex == 10'sd0) begin
         s4_res_in = xs[30:0];
      end else begin
         s4_res_in = {ex[7:0], rsum[24] ? 23'd0 : rsum[22:0]};
      end
   end

   // Advance the control of every stage
   always_ff @(posedge clock) begin
      if (reset) begin
         s1_ctl_ff.valid <= 1'b0;
         s2_valid_ff <= 1'b0;
         s3_valid_ff <= 1'b0;
         s4_valid_ff <= 1'b0;
      end else if (adv) begin
         s1_ctl_ff <= s1_ctl_in;
         s2_valid_ff <= s1_ctl_ff.valid;
         s3_valid_ff <= s2_valid_ff;
         s4_valid_ff <= s3_valid_ff;
      end
   end

   // Advance the payload of every stage
   always_ff @(posedge clock) begin
      if (adv) begin
         s1_mag_ff <= s1_mag_in;
         s1_v0_ff <= v0;
         s1_v1_ff <= v1;
         s1_up_ff <= s1_up_in;
         s1_k_ff <= s1_k_in;
         s2_flag_ff <= s1_ctl_ff.flag;
         s2_x_ff <= s2_x_in;
         s2_kk_ff <= s2_kk_in;
         s3_flag_ff <= s2_flag_ff;
         s3_x_ff <= s2_x_ff;
         s3_kk_ff <= s2_kk_ff;
         s3_lead_ff <= s3_lead_in;
         s4_flag_ff <= s3_flag_ff;
         s4_res_ff <= s4_res_in;
      end
   end

   assign res_valid = s4_valid_ff;
   assign res_bits = s4_res_ff;
   assign res_flag = s4_flag_ff;

endmodule

// ===== sv/uti_checker.sv =====
// Port-level checker for the u16 table linear interpolator, with its bind.
// Depends on u16_table_linear_interpolator_assert.svh.
`include "u16_table_linear_interpolator_assert.svh"

module uti_checker (
   input logic        clock,
   input logic        reset,
   input logic        req_tready,
   input logic        rsp_tvalid,
   input logic        rsp_tready,
   input logic [31:0] rsp_tdata,
   input logic        rsp_tuser
);

   // A waiting result stays offered
   `UTI_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_tvalid && !rsp_tready, rsp_tvalid)
   // Input is taken whenever the output side can move
   `UTI_ASSERT_SAME(a_ready, clock, reset, 1'b1, req_tready == (!rsp_tvalid || rsp_tready))
   // A result never exceeds the largest cell value
   `UTI_ASSERT_SAME(a_range, clock, reset, rsp_tvalid, rsp_tdata <= 32'h477FFF00)
   // A flagged result has bit 31, the zero fill, clear
   `UTI_ASSERT_SAME(a_flag, clock, reset, rsp_tvalid && rsp_tuser, rsp_tdata[31] == 1'b0)

endmodule

bind u16_table_linear_interpolator uti_checker u_chk (.*);
